>>> hdl/sha256_pkg.sv
// Package with SHA-256 constants, tables and round functions.
`default_nettype none
package sha256_pkg;

  typedef logic [31:0] word_t;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenStartPos = 6'd56;

  function automatic word_t init_hash(input logic [2:0] idx);
    word_t v;
    case (idx)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      default: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  function automatic word_t round_k(input logic [5:0] idx);
    word_t v;
    case (idx)
      6'd0: v = 32'h428a2f98;  6'd1: v = 32'h71374491;  6'd2: v = 32'hb5c0fbcf;
      6'd3: v = 32'he9b5dba5;  6'd4: v = 32'h3956c25b;  6'd5: v = 32'h59f111f1;
      6'd6: v = 32'h923f82a4;  6'd7: v = 32'hab1c5ed5;  6'd8: v = 32'hd807aa98;
      6'd9: v = 32'h12835b01;  6'd10: v = 32'h243185be; 6'd11: v = 32'h550c7dc3;
      6'd12: v = 32'h72be5d74; 6'd13: v = 32'h80deb1fe; 6'd14: v = 32'h9bdc06a7;
      6'd15: v = 32'hc19bf174; 6'd16: v = 32'he49b69c1; 6'd17: v = 32'hefbe4786;
      6'd18: v = 32'h0fc19dc6; 6'd19: v = 32'h240ca1cc; 6'd20: v = 32'h2de92c6f;
      6'd21: v = 32'h4a7484aa; 6'd22: v = 32'h5cb0a9dc; 6'd23: v = 32'h76f988da;
      6'd24: v = 32'h983e5152; 6'd25: v = 32'ha831c66d; 6'd26: v = 32'hb00327c8;
      6'd27: v = 32'hbf597fc7; 6'd28: v = 32'hc6e00bf3; 6'd29: v = 32'hd5a79147;
      6'd30: v = 32'h06ca6351; 6'd31: v = 32'h14292967; 6'd32: v = 32'h27b70a85;
      6'd33: v = 32'h2e1b2138; 6'd34: v = 32'h4d2c6dfc; 6'd35: v = 32'h53380d13;
      6'd36: v = 32'h650a7354; 6'd37: v = 32'h766a0abb; 6'd38: v = 32'h81c2c92e;
      6'd39: v = 32'h92722c85; 6'd40: v = 32'ha2bfe8a1; 6'd41: v = 32'ha81a664b;
      6'd42: v = 32'hc24b8b70; 6'd43: v = 32'hc76c51a3; 6'd44: v = 32'hd192e819;
      6'd45: v = 32'hd6990624; 6'd46: v = 32'hf40e3585; 6'd47: v = 32'h106aa070;
      6'd48: v = 32'h19a4c116; 6'd49: v = 32'h1e376c08; 6'd50: v = 32'h2748774c;
      6'd51: v = 32'h34b0bcb5; 6'd52: v = 32'h391c0cb3; 6'd53: v = 32'h4ed8aa4a;
      6'd54: v = 32'h5b9cca4f; 6'd55: v = 32'h682e6ff3; 6'd56: v = 32'h748f82ee;
      6'd57: v = 32'h78a5636f; 6'd58: v = 32'h84c87814; 6'd59: v = 32'h8cc70208;
      6'd60: v = 32'h90befffa; 6'd61: v = 32'ha4506ceb; 6'd62: v = 32'hbef9a3f7;
      default: v = 32'hc67178f2;
    endcase
    return v;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t sig0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sig1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage
`default_nettype wire

>>> hdl/sha256_if.sv
// Stream interfaces for the byte input and the digest output.
`default_nettype none
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] message_byte;
  logic       byte_present;
  logic       last_item;
  modport source (output valid, message_byte, byte_present, last_item, input ready);
  modport sink (input valid, message_byte, byte_present, last_item, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_bits_255_192;
  logic [63:0] digest_bits_191_128;
  logic [63:0] digest_bits_127_64;
  logic [63:0] digest_bits_63_0;
  modport source (output valid, digest_bits_255_192, digest_bits_191_128,
                  digest_bits_127_64, digest_bits_63_0, input ready);
  modport sink (input valid, digest_bits_255_192, digest_bits_191_128,
                digest_bits_127_64, digest_bits_63_0, output ready);
endinterface
`default_nettype wire

>>> hdl/sha256_message_hasher.sv
// Top level of the SHA-256 message hasher: byte packing, padding and round engine.
`default_nettype none
// At most one message byte is taken per input transfer and packed
// big-endian into a 16-word memory, which then also serves as the rolling
// message schedule. The byte that fills a block starts the compression,
// and the input is not ready while it runs. Each of the 64 rounds reads
// the three schedule taps and the slot itself through the memory's single
// read port, then does the round arithmetic; the final hash addition
// closes the block. A last transfer pads the message one byte per cycle
// between compressions: the marker byte, then zeros, then the 64-bit
// big-endian bit length. Padding takes one or two further compressions
// before the digest appears. The digest is presented as four 64-bit words,
// with word 0 of the hash in the top half of the first field. The output
// register holds a digest until it is taken. The next message may already
// stream in meanwhile, but a further last transfer waits until the output
// is free. Memory words are always written before they are read, so there
// is no clearing pass.
module sha256_message_hasher (
  input wire clk,
  input wire rst_n,
  sha256_in_if.sink    in_ch,
  sha256_out_if.source out_ch
);
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StPad   = 3'd1;
  localparam logic [2:0] StRead  = 3'd2;
  localparam logic [2:0] StRound = 3'd3;
  localparam logic [2:0] StAdd   = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [5:0]  count_r, count_nxt;       // bytes in the block
  logic [63:0] len_r, len_nxt;           // message bit length
  logic [63:0] flen_r, flen_nxt;         // length latched for padding
  logic        padding_r, padding_nxt;   // finishing the message
  logic        mark_r, mark_nxt;         // marker byte still to be placed
  logic        lenok_r, lenok_nxt;       // length bytes close this block
  logic        done_r, done_nxt;         // block in flight holds the length
  logic [5:0]  round_r, round_nxt;
  logic [1:0]  tap_r, tap_nxt;           // schedule read phase
  sha256_pkg::word_t hash_r [8];
  sha256_pkg::word_t hash_nxt [8];
  sha256_pkg::word_t var_r [8];
  sha256_pkg::word_t var_nxt [8];
  sha256_pkg::word_t partial_r, partial_nxt; // word being packed
  sha256_pkg::word_t x15_r, x15_nxt;
  sha256_pkg::word_t acc_r, acc_nxt;         // schedule sum without the slot word
  sha256_pkg::word_t pre_r, pre_nxt;         // h + Sigma1(e) + Ch + K
  sha256_pkg::word_t t2_r, t2_nxt;
  logic        ov_r, ov_nxt;
  logic [255:0] dig_r, dig_nxt;

  logic        we;
  logic [3:0]  waddr, raddr;
  sha256_pkg::word_t wdata, rdata;

  sha256_ram #(.Width(32), .Depth(16)) u_sched (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // Byte placed this cycle, from the input or from the padding sequence.
  logic        put;
  logic [7:0]  put_byte;
  sha256_pkg::word_t packed_word;
  logic        in_xfer;
  logic [2:0]  len_sel;
  sha256_pkg::word_t w_new, w_use, t1;

  assign in_ch.ready = (state_r == StIdle) && !(in_ch.last_item && ov_r);
  assign in_xfer = in_ch.valid && in_ch.ready;
  assign len_sel = 3'd7 - count_r[2:0];

  always_comb begin
    put = 1'b0;
    put_byte = in_ch.message_byte;
    if (state_r == StIdle) begin
      put = in_xfer && in_ch.byte_present;
    end else if (state_r == StPad) begin
      put = 1'b1;
      if (mark_r) put_byte = sha256_pkg::PadByte;
      else if (lenok_r && count_r >= sha256_pkg::LenStartPos)
        put_byte = flen_r[{len_sel, 3'b000} +: 8];
      else put_byte = 8'h00;
    end
    case (count_r[1:0])
      2'd0:    packed_word = {put_byte, 24'h0};
      2'd1:    packed_word = {partial_r[31:24], put_byte, 16'h0};
      2'd2:    packed_word = {partial_r[31:16], put_byte, 8'h0};
      default: packed_word = {partial_r[31:8], put_byte};
    endcase
  end

  // Round datapath. The tap sum, most of t1 and all of t2 are prepared during
  // the read phases, so the round cycle only adds the slot word and finishes a and e.
  always_comb begin
    w_new = rdata + acc_r;
    w_use = (round_r < 6'd16) ? rdata : w_new;
    t1 = pre_r + w_use;
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    len_nxt = len_r;
    flen_nxt = flen_r;
    padding_nxt = padding_r;
    mark_nxt = mark_r;
    lenok_nxt = lenok_r;
    done_nxt = done_r;
    round_nxt = round_r;
    tap_nxt = tap_r;
    hash_nxt = hash_r;
    var_nxt = var_r;
    partial_nxt = partial_r;
    x15_nxt = x15_r;
    acc_nxt = acc_r;
    pre_nxt = pre_r;
    t2_nxt = t2_r;
    ov_nxt = ov_r;
    dig_nxt = dig_r;
    we = 1'b0;
    waddr = count_r[5:2];
    wdata = packed_word;
    raddr = round_r[3:0];

    if (out_ch.valid && out_ch.ready) ov_nxt = 1'b0;

    if (put) begin
      partial_nxt = packed_word;
      we = 1'b1;
      count_nxt = count_r + 6'd1;
    end

    case (state_r)
      StIdle: begin
        if (in_xfer) begin
          if (in_ch.byte_present) len_nxt = len_r + 64'd8;
          if (in_ch.last_item) begin
            padding_nxt = 1'b1;
            mark_nxt = 1'b1;
            lenok_nxt = 1'b0;
            done_nxt = 1'b0;
            flen_nxt = in_ch.byte_present ? len_r + 64'd8 : len_r;
            state_nxt = StPad;
          end
          // A full block is compressed first; padding follows afterwards.
          if (put && count_r == 6'd63) begin
            state_nxt = StRead;
            round_nxt = 6'd0;
            tap_nxt = 2'd0;
            var_nxt = hash_r;
          end
        end
      end
      StPad: begin
        // A marker that lands before the length field leaves room for the
        // length in the same block; otherwise it goes into the next one.
        if (mark_r) begin
          mark_nxt = 1'b0;
          if (count_r < sha256_pkg::LenStartPos) lenok_nxt = 1'b1;
        end
        if (count_r == 6'd63) begin
          if (lenok_r) done_nxt = 1'b1;
          else lenok_nxt = 1'b1;
          state_nxt = StRead;
          round_nxt = 6'd0;
          tap_nxt = 2'd0;
          var_nxt = hash_r;
        end
      end
      StRead: begin
        // Phases: read x15, x2, x7, then the slot itself.
        tap_nxt = tap_r + 2'd1;
        case (tap_r)
          2'd0: begin
            raddr = round_r[3:0] + 4'd1;
            pre_nxt = var_r[7] + sha256_pkg::bsig1(var_r[4]) +
                      ((var_r[4] & var_r[5]) ^ (~var_r[4] & var_r[6])) +
                      sha256_pkg::round_k(round_r);
            t2_nxt = sha256_pkg::bsig0(var_r[0]) +
                     ((var_r[0] & var_r[1]) ^ (var_r[0] & var_r[2]) ^ (var_r[1] & var_r[2]));
          end
          2'd1: begin
            raddr = round_r[3:0] + 4'd14;
            x15_nxt = rdata;
          end
          2'd2: begin
            raddr = round_r[3:0] + 4'd9;
            acc_nxt = sha256_pkg::sig0(x15_r) + sha256_pkg::sig1(rdata);
          end
          default: begin
            raddr = round_r[3:0];
            acc_nxt = acc_r + rdata;
            state_nxt = StRound;
          end
        endcase
      end
      StRound: begin
        if (round_r >= 6'd16) begin
          we = 1'b1;
          waddr = round_r[3:0];
          wdata = w_new;
        end
        var_nxt[7] = var_r[6];
        var_nxt[6] = var_r[5];
        var_nxt[5] = var_r[4];
        var_nxt[4] = var_r[3] + t1;
        var_nxt[3] = var_r[2];
        var_nxt[2] = var_r[1];
        var_nxt[1] = var_r[0];
        var_nxt[0] = t1 + t2_r;
        tap_nxt = 2'd0;
        round_nxt = round_r + 6'd1;
        state_nxt = (round_r == 6'd63) ? StAdd : StRead;
      end
      StAdd: begin
        for (int i = 0; i < 8; i++) hash_nxt[i] = hash_r[i] + var_r[i];
        if (!padding_r) state_nxt = StIdle;
        else if (done_r) state_nxt = StOut;
        else state_nxt = StPad;
      end
      StOut: begin
        if (!ov_r) begin
          for (int i = 0; i < 8; i++) begin
            dig_nxt[255-32*i -: 32] = hash_r[i];
            hash_nxt[i] = sha256_pkg::init_hash(3'(i));
          end
          ov_nxt = 1'b1;
          len_nxt = 64'd0;
          padding_nxt = 1'b0;
          lenok_nxt = 1'b0;
          done_nxt = 1'b0;
          state_nxt = StIdle;
        end
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
      count_r <= '0;
      len_r <= '0;
      padding_r <= 1'b0;
      mark_r <= 1'b0;
      lenok_r <= 1'b0;
      done_r <= 1'b0;
      round_r <= '0;
      tap_r <= '0;
      ov_r <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= sha256_pkg::init_hash(3'(i));
        var_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      len_r <= len_nxt;
      padding_r <= padding_nxt;
      mark_r <= mark_nxt;
      lenok_r <= lenok_nxt;
      done_r <= done_nxt;
      round_r <= round_nxt;
      tap_r <= tap_nxt;
      ov_r <= ov_nxt;
      hash_r <= hash_nxt;
      var_r <= var_nxt;
    end
    flen_r <= flen_nxt;
    partial_r <= partial_nxt;
    x15_r <= x15_nxt;
    acc_r <= acc_nxt;
    pre_r <= pre_nxt;
    t2_r <= t2_nxt;
    dig_r <= dig_nxt;
  end

  assign out_ch.valid = ov_r;
  assign out_ch.digest_bits_255_192 = dig_r[255:192];
  assign out_ch.digest_bits_191_128 = dig_r[191:128];
  assign out_ch.digest_bits_127_64  = dig_r[127:64];
  assign out_ch.digest_bits_63_0    = dig_r[63:0];

  round_after_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == StRound) |-> (tap_r == 2'd0))
    else $error("round without full tap read");
  out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ch.ready) |=> ov_r && $stable(dig_r))
    else $error("digest dropped or changed before transfer");
  busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != StIdle) |-> !in_ch.ready)
    else $error("input taken while compressing");
endmodule
`default_nettype wire

>>> hdl/sha256_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module sha256_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(Depth)-1:0] waddr,
  input  wire [Width-1:0]         wdata,
  input  wire [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]        rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
